@@ design/fppd_pkg.sv @@
package fppd_pkg;

	localparam int FIELD_BITS     = 16;
	localparam int TIME_BITS      = 32;
	localparam int CNT_BITS       = 32;
	localparam int THR_BITS       = 16;
	localparam int HOLD_BITS      = 16;
	localparam int SHARE_BITS     = 9;
	localparam int SHARE_FRAC     = 8;
	localparam int CFG_IDX_BITS   = 2;
	localparam int CFG_DATA_BITS  = 16;
	localparam int FIXED_DWELL_MS = 150;
	localparam int MIN_Z_MAG      = 2;
	localparam int PROD_BITS      = FIELD_BITS + SHARE_BITS;

	localparam logic [CFG_IDX_BITS-1:0] REG_MODE      = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_HOLD      = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_Z_SHARE   = 2'd3;

	localparam logic [1:0] MODE_SIMPLE = 2'd0;
	localparam logic [1:0] MODE_DWELL  = 2'd1;
	localparam logic [1:0] MODE_ZDOM   = 2'd2;

	localparam logic [1:0] EV_NONE     = 2'd0;
	localparam logic [1:0] EV_PAIRED   = 2'd1;
	localparam logic [1:0] EV_UNPAIRED = 2'd2;

	localparam logic [1:0] PHASE_CODE_IDLE   = 2'd0;
	localparam logic [1:0] PHASE_CODE_DWELL  = 2'd1;
	localparam logic [1:0] PHASE_CODE_PAIRED = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_DWELL  = 3'b010,
		PH_PAIRED = 3'b100
	} phase_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0]        field_magnitude;
		logic signed [FIELD_BITS-1:0] z_component;
		logic [TIME_BITS-1:0]         sample_time_ms;
	} sample_t;

	typedef struct packed {
		logic [1:0]          event_code;
		logic [1:0]          current_phase;
		logic [CNT_BITS-1:0] pairs_total;
		logic [CNT_BITS-1:0] blocked_total;
		logic [CNT_BITS-1:0] last_pair_ms;
	} result_t;

	typedef struct packed {
		logic [1:0]            mode_select;
		logic [THR_BITS-1:0]   field_threshold;
		logic [HOLD_BITS-1:0]  hold_time_ms;
		logic [SHARE_BITS-1:0] z_share_min;
	} cfg_t;

	typedef struct packed {
		phase_t               phase;
		logic [TIME_BITS-1:0] dwell_begin_ms;
		logic [CNT_BITS-1:0]  pair_counter;
		logic [CNT_BITS-1:0]  blocked_counter;
		logic [TIME_BITS-1:0] last_pair_time;
	} state_t;

	function automatic logic [1:0] phase_code(input phase_t ph);
		logic [1:0] code;
		case (ph)
			PH_DWELL:  code = PHASE_CODE_DWELL;
			PH_PAIRED: code = PHASE_CODE_PAIRED;
			default:   code = PHASE_CODE_IDLE;
		endcase
		return code;
	endfunction

endpackage

@@ design/fppd_cfg_regs.sv @@
module fppd_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [fppd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [fppd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output fppd_pkg::cfg_t                       cfg
);
	import fppd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode_select     <= MODE_SIMPLE;
			cfg_q.field_threshold <= THR_BITS'(80);
			cfg_q.hold_time_ms    <= HOLD_BITS'(150);
			cfg_q.z_share_min     <= SHARE_BITS'(179);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MODE:      cfg_q.mode_select     <= cfg_data[1:0];
				REG_THRESHOLD: cfg_q.field_threshold <= cfg_data[THR_BITS-1:0];
				REG_HOLD:      cfg_q.hold_time_ms    <= cfg_data[HOLD_BITS-1:0];
				REG_Z_SHARE:   cfg_q.z_share_min     <= cfg_data[SHARE_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/fppd_step.sv @@
module fppd_step (
	input  fppd_pkg::cfg_t    cfg,
	input  fppd_pkg::state_t  cur,
	input  fppd_pkg::sample_t smp,
	output fppd_pkg::state_t  nxt,
	output logic [1:0]        event_code
);
	import fppd_pkg::*;

	logic [FIELD_BITS-1:0] mag;
	logic [FIELD_BITS-1:0] zabs;
	logic [TIME_BITS-1:0]  now;
	logic [TIME_BITS-1:0]  elapsed;
	logic [PROD_BITS-1:0]  z_scaled;
	logic [PROD_BITS-1:0]  share_prod;
	logic                  over_thr;
	logic                  below;
	logic                  under_half;
	logic                  zdom;
	logic                  hold_done;
	logic                  fixed_done;

	assign mag     = smp.field_magnitude;
	assign zabs    = smp.z_component[FIELD_BITS-1] ? FIELD_BITS'(-smp.z_component)
	                                               : FIELD_BITS'(smp.z_component);
	assign now     = smp.sample_time_ms;
	assign elapsed = now - cur.dwell_begin_ms;

	assign over_thr   = mag > cfg.field_threshold;
	assign below      = mag < cfg.field_threshold;
	assign under_half = {1'b0, mag, 1'b0} < {2'b00, cfg.field_threshold};

	// |z|*256 against share*magnitude, exact
	assign z_scaled   = PROD_BITS'({zabs, {SHARE_FRAC{1'b0}}});
	assign share_prod = PROD_BITS'(cfg.z_share_min) * PROD_BITS'(mag);
	assign zdom = (mag >= FIELD_BITS'(MIN_Z_MAG)) ? (z_scaled >= share_prod)
	                                              : (cfg.z_share_min == '0);

	assign hold_done  = elapsed >= TIME_BITS'(cfg.hold_time_ms);
	assign fixed_done = elapsed >= TIME_BITS'(FIXED_DWELL_MS);

	always_comb begin
		nxt        = cur;
		event_code = EV_NONE;
		if (cur.phase == PH_PAIRED) begin
			if (under_half) begin
				nxt.phase  = PH_IDLE;
				event_code = EV_UNPAIRED;
			end
		end else begin
			case (cfg.mode_select)
				MODE_DWELL: begin
					if (cur.phase == PH_IDLE) begin
						if (over_thr) begin
							nxt.phase          = PH_DWELL;
							nxt.dwell_begin_ms = now;
						end
					end else if (below) begin
						nxt.phase = PH_IDLE;
					end else if (hold_done) begin
						nxt.phase          = PH_PAIRED;
						nxt.pair_counter   = cur.pair_counter + CNT_BITS'(1);
						nxt.last_pair_time = now;
						event_code         = EV_PAIRED;
					end
				end
				MODE_ZDOM: begin
					if (cur.phase == PH_IDLE) begin
						if (over_thr && zdom) begin
							nxt.phase          = PH_DWELL;
							nxt.dwell_begin_ms = now;
						end else if (over_thr) begin
							nxt.blocked_counter = cur.blocked_counter + CNT_BITS'(1);
						end
					end else if (below || !zdom) begin
						nxt.phase = PH_IDLE;
					end else if (fixed_done) begin
						nxt.phase          = PH_PAIRED;
						nxt.pair_counter   = cur.pair_counter + CNT_BITS'(1);
						nxt.last_pair_time = now;
						event_code         = EV_PAIRED;
					end
				end
				default: begin
					// simple threshold, also the unused mode code
					if (cur.phase == PH_IDLE) begin
						if (over_thr) begin
							nxt.phase          = PH_PAIRED;
							nxt.pair_counter   = cur.pair_counter + CNT_BITS'(1);
							nxt.last_pair_time = now;
							event_code         = EV_PAIRED;
						end
					end else begin
						nxt.phase = PH_IDLE;
					end
				end
			endcase
		end
	end

endmodule

@@ design/field_proximity_pairing_detector.sv @@
// channel  | valid         | ready         | beat
// ---------+---------------+---------------+----------------------------
// sample   | sample_valid  | sample_ready  | sample  (fppd_pkg::sample_t)
// result   | result_valid  | result_ready  | result  (fppd_pkg::result_t)
// config   | cfg_wr_en     | (none)        | cfg_index, cfg_data
//
// one beat per cycle sustained while result_ready is high; a sample beat goes into
// the input register, then through the state update into the result register,
// where its result is valid and can be taken
// the sample register refills in the same cycle the result register is taken
// asynchronous low reset sets idle phase, zero counters and register defaults
// a stalled result holds; the sample register holds one more beat behind it
module field_proximity_pairing_detector (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  fppd_pkg::sample_t                   sample,
	output logic                                result_valid,
	input  logic                                result_ready,
	output fppd_pkg::result_t                   result,
	input  logic                                cfg_wr_en,
	input  logic [fppd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [fppd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import fppd_pkg::*;

	cfg_t      cfg;
	state_t    st_q;
	state_t    st_nxt;
	logic [1:0] ev;
	sample_t   smp_s1;
	logic      valid_s1;
	result_t   res_s2;
	logic      valid_s2;
	logic      advance;

	fppd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fppd_step u_step (
		.cfg        (cfg),
		.cur        (st_q),
		.smp        (smp_s1),
		.nxt        (st_nxt),
		.event_code (ev)
	);

	assign advance      = valid_s1 && (!valid_s2 || result_ready);
	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			smp_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase           <= PH_IDLE;
			st_q.dwell_begin_ms  <= '0;
			st_q.pair_counter    <= '0;
			st_q.blocked_counter <= '0;
			st_q.last_pair_time  <= '0;
			valid_s2             <= 1'b0;
		end else if (advance) begin
			st_q     <= st_nxt;
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2.event_code    <= ev;
			res_s2.current_phase <= phase_code(st_nxt.phase);
			res_s2.pairs_total   <= st_nxt.pair_counter;
			res_s2.blocked_total <= st_nxt.blocked_counter;
			res_s2.last_pair_ms  <= st_nxt.last_pair_time[CNT_BITS-1:0];
		end
	end

	assign result_valid = valid_s2;
	assign result       = res_s2;

endmodule
